/* hdl/fsss_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsss_pkg
// Shared types, constants and the segment glyph table for the four-digit
// seven-segment scanner.
// ----------------------------------------------------------------------------
package fsss_pkg;

  localparam int DIGITS  = 4;
  localparam int POS_W   = 2;
  localparam int SEG_W   = 8;
  localparam int VALUE_W = 17;
  localparam int DATA_W  = 16;
  localparam int MAG_W   = 14;
  localparam int QUO_W   = 11;
  localparam int CFG_W   = 2;

  // Reciprocal of ten: floor(x / 10) == (x * RECIP) >> RECIP_SHIFT for x < 43699
  localparam int RECIP_W     = 16;
  localparam int PROD_W      = MAG_W + RECIP_W;
  localparam int RECIP_SHIFT = 19;
  localparam logic [RECIP_W-1:0] RECIP = 16'd52429;

  // Decimal display limits
  localparam logic signed [VALUE_W-1:0] DEC_MAX = 17'sd9999;
  localparam logic signed [VALUE_W-1:0] DEC_MIN = -17'sd999;

  // Special segment patterns, A..G,P from bit 7 down
  localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;
  localparam logic [SEG_W-1:0] SEG_MINUS = 8'h02;
  localparam logic [SEG_W-1:0] SEG_TOP   = 8'h80;
  localparam logic [SEG_W-1:0] SEG_LOW   = 8'h10;

  // Configuration register indexes
  localparam logic [CFG_W-1:0] CFG_HEX_MODE       = 2'd0;
  localparam logic [CFG_W-1:0] CFG_COMMON_CATHODE = 2'd1;

  // What the back end has to do with one tick
  typedef enum logic [2:0] {
    K_SHOW,     // show a kept pattern (digits 1 to 3)
    K_HEX,      // refill from four nibbles
    K_OVER,     // refill with top bars
    K_UNDER,    // refill with underscores
    K_DEC_POS,  // refill with a non-negative decimal
    K_DEC_NEG   // refill with a negative decimal
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] data;  // raw nibbles in hex, magnitude in decimal
  } entry_t;

  function automatic logic [SEG_W-1:0] glyph(input logic [3:0] nib);
    logic [SEG_W-1:0] seg;
    case (nib)
      4'h0: seg = 8'hFC;
      4'h1: seg = 8'h60;
      4'h2: seg = 8'hDA;
      4'h3: seg = 8'hF2;
      4'h4: seg = 8'h66;
      4'h5: seg = 8'hB6;
      4'h6: seg = 8'hBE;
      4'h7: seg = 8'hE0;
      4'h8: seg = 8'hFE;
      4'h9: seg = 8'hF6;
      4'hA: seg = 8'hEE;
      4'hB: seg = 8'h3E;
      4'hC: seg = 8'h9C;
      4'hD: seg = 8'h7A;
      4'hE: seg = 8'h9E;
      default: seg = 8'h8E;
    endcase
    return seg;
  endfunction

endpackage

/* hdl/fsss_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsss_front
// Accepts refresh ticks, tracks the scan position and classifies each tick
// for the back end (show kept pattern, hex, overflow marks or decimal).
// ----------------------------------------------------------------------------
module fsss_front import fsss_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [VALUE_W-1:0] shown_value_i,
  input  logic                      hex_mode_i,
  input  logic                      full_i,
  output logic                      push_o,
  output entry_t                    entry_o
);

  logic [POS_W-1:0]          pos_q, pos_d;
  logic signed [VALUE_W-1:0] neg_value;
  logic signed [VALUE_W-1:0] abs_value;

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  // Classify the tick
  always_comb begin
    neg_value     = -shown_value_i;
    abs_value     = shown_value_i[VALUE_W-1] ? neg_value : shown_value_i;
    entry_o.pos   = pos_q;
    entry_o.data  = {{(DATA_W-MAG_W){1'b0}}, abs_value[MAG_W-1:0]};
    if (pos_q != '0) begin
      entry_o.kind = K_SHOW;
    end else if (hex_mode_i) begin
      entry_o.kind = K_HEX;
      entry_o.data = shown_value_i[DATA_W-1:0];
    end else if (shown_value_i > DEC_MAX) begin
      entry_o.kind = K_OVER;
    end else if (shown_value_i < DEC_MIN) begin
      entry_o.kind = K_UNDER;
    end else if (shown_value_i[VALUE_W-1]) begin
      entry_o.kind = K_DEC_NEG;
    end else begin
      entry_o.kind = K_DEC_POS;
    end
  end

  // Advance the scan position on each transaction
  always_comb begin
    pos_d = pos_q;
    if (push_o) begin
      pos_d = (pos_q == POS_W'(DIGITS - 1)) ? '0 : pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

/* hdl/fsss_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsss_queue
// Small first-in first-out queue of classified ticks between front and back.
// ----------------------------------------------------------------------------
module fsss_queue import fsss_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   valid_o,
  output entry_t entry_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   count_q;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];

  // Write the entry at the tail
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

/* hdl/fsss_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsss_back
// Fills the pattern store (hex, overflow marks, or decimal digits one per
// cycle by reciprocal multiply) and drives the registered output transaction.
// ----------------------------------------------------------------------------
module fsss_back import fsss_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               common_cathode_i,
  input  logic               head_valid_i,
  input  entry_t             head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [SEG_W-1:0]   segment_lines_o,
  output logic [DIGITS-1:0]  digit_enables_o,
  output logic [POS_W-1:0]   digit_position_o
);

  typedef enum logic [1:0] {
    ST_TAKE,
    ST_CONV,
    ST_EMIT
  } state_e;

  state_e             state_q;
  logic [SEG_W-1:0]   store_q [DIGITS];
  logic [MAG_W-1:0]   mag_q;
  logic [POS_W-1:0]   idx_q;
  logic               neg_q;
  logic               out_valid_q;
  logic [SEG_W-1:0]   seg_q;
  logic [DIGITS-1:0]  en_q;
  logic [POS_W-1:0]   pos_q;

  logic               out_free;
  logic               out_load;
  logic               is_dec;
  logic [SEG_W-1:0]   fill_pat [DIGITS];
  logic [PROD_W-1:0]  prod;
  logic [QUO_W-1:0]   quo;
  logic [MAG_W-1:0]   rem_full;
  logic [SEG_W-1:0]   conv_pat;

  // Apply display polarity to a pattern and a position
  function automatic logic [SEG_W+DIGITS-1:0] polar(input logic [SEG_W-1:0] seg,
                                                     input logic [POS_W-1:0] pos,
                                                     input logic cc);
    logic [DIGITS-1:0] en;
    en = DIGITS'(1) << pos;
    return cc ? {seg, ~en} : {~seg, en};
  endfunction

  assign out_free = !out_valid_q || !out_stall_i;
  assign is_dec   = (head_i.kind == K_DEC_POS) || (head_i.kind == K_DEC_NEG);
  assign pop_o    = (state_q == ST_TAKE) && head_valid_i && (is_dec || out_free);
  assign out_load = (pop_o && !is_dec) || ((state_q == ST_EMIT) && out_free);

  // Build the fill patterns for hex and overflow ticks
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      case (head_i.kind)
        K_OVER:  fill_pat[i] = SEG_TOP;
        K_UNDER: fill_pat[i] = SEG_LOW;
        default: fill_pat[i] = glyph(head_i.data[4*(DIGITS-1-i) +: 4]);
      endcase
    end
  end

  // Take one decimal digit off the magnitude
  always_comb begin
    prod     = PROD_W'(mag_q) * PROD_W'(RECIP);
    quo      = prod[RECIP_SHIFT +: QUO_W];
    rem_full = mag_q - MAG_W'({quo, 3'b000}) - MAG_W'({quo, 1'b0});
    if (mag_q != '0) begin
      conv_pat = glyph(rem_full[3:0]);
    end else if (idx_q == POS_W'(DIGITS - 1)) begin
      conv_pat = glyph(4'h0);
    end else begin
      conv_pat = SEG_BLANK;
    end
  end

  // Sequence the back end and hold the output transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_TAKE;
      out_valid_q <= 1'b0;
      mag_q       <= '0;
      idx_q       <= '0;
      neg_q       <= 1'b0;
      seg_q       <= '0;
      en_q        <= '0;
      pos_q       <= '0;
      for (int i = 0; i < DIGITS; i++) begin
        store_q[i] <= SEG_BLANK;
      end
    end else begin
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
      unique case (state_q)
        ST_TAKE: begin
          if (pop_o) begin
            unique case (head_i.kind) inside
              K_SHOW: begin
                {seg_q, en_q} <= polar(store_q[head_i.pos], head_i.pos, common_cathode_i);
                pos_q         <= head_i.pos;
              end
              K_HEX, K_OVER, K_UNDER: begin
                for (int i = 0; i < DIGITS; i++) begin
                  store_q[i] <= fill_pat[i];
                end
                {seg_q, en_q} <= polar(fill_pat[0], '0, common_cathode_i);
                pos_q         <= '0;
              end
              default: begin
                mag_q   <= head_i.data[MAG_W-1:0];
                neg_q   <= (head_i.kind == K_DEC_NEG);
                idx_q   <= POS_W'(DIGITS - 1);
                state_q <= ST_CONV;
              end
            endcase
          end
        end
        ST_CONV: begin
          store_q[idx_q] <= (idx_q == '0 && neg_q) ? SEG_MINUS : conv_pat;
          mag_q          <= MAG_W'(quo);
          idx_q          <= idx_q - 1'b1;
          if (idx_q == '0) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            {seg_q, en_q} <= polar(store_q[0], '0, common_cathode_i);
            pos_q         <= '0;
            state_q       <= ST_TAKE;
          end
        end
        default: begin
          state_q <= ST_TAKE;
        end
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign segment_lines_o  = seg_q;
  assign digit_enables_o  = en_q;
  assign digit_position_o = pos_q;

endmodule

/* hdl/four_digit_seven_segment_scanner_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_digit_seven_segment_scanner_top
// Multiplexed four-digit seven-segment driver: one refresh tick in, one
// digit's segments and enables out.
// ----------------------------------------------------------------------------
//  channel | handshake               | payload
//  --------+-------------------------+------------------------------------------
//  in      | in_valid_i / in_stall_o | shown_value_i
//  out     | out_valid_o/out_stall_i | segment_lines_o, digit_enables_o,
//          |                         | digit_position_o
//  cfg     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// Ticks for digits 1 to 3 and hex or overflow ticks for digit 0 are loaded
// into the output register as the back end takes them. A decimal tick for
// digit 0 is taken, makes four passes through the shared divide-by-ten unit
// (one digit per cycle) and is then loaded into the output register.
// Reset needs no clearing pass: digit 0 comes first and rewrites the store.
// A queue of QUEUE_DEPTH ticks and the output register let input and output
// stall independently.
// ----------------------------------------------------------------------------
module four_digit_seven_segment_scanner_top import fsss_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [VALUE_W-1:0] shown_value_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [SEG_W-1:0]          segment_lines_o,
  output logic [DIGITS-1:0]         digit_enables_o,
  output logic [POS_W-1:0]          digit_position_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CFG_W-1:0]          cfg_index_i,
  input  logic                      cfg_data_i
);

  logic   hex_mode_q;
  logic   common_cathode_q;
  logic   push;
  logic   full;
  logic   pop;
  logic   head_valid;
  entry_t push_entry;
  entry_t head_entry;

  assign cfg_ready_o = 1'b1;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hex_mode_q       <= 1'b0;
      common_cathode_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_HEX_MODE:       hex_mode_q       <= cfg_data_i;
        CFG_COMMON_CATHODE: common_cathode_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  fsss_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .shown_value_i (shown_value_i),
    .hex_mode_i    (hex_mode_q),
    .full_i        (full),
    .push_o        (push),
    .entry_o       (push_entry)
  );

  fsss_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .entry_o (head_entry)
  );

  fsss_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .common_cathode_i (common_cathode_q),
    .head_valid_i     (head_valid),
    .head_i           (head_entry),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .segment_lines_o  (segment_lines_o),
    .digit_enables_o  (digit_enables_o),
    .digit_position_o (digit_position_o)
  );

  // Back end only takes transactions the queue holds
  a_pop_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head_valid)
    else $error("back end popped an empty queue");

  // Exactly the current digit is enabled, in the configured polarity
  a_enable_matches_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((common_cathode_q ? ~digit_enables_o : digit_enables_o)
                     == (DIGITS'(1) << digit_position_o)))
    else $error("digit enable does not match digit position");

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the four-digit seven-segment scanner. Refresh ticks
// are driven with random gaps. Every tick is predicted from a local copy of
// the scan position, kept glyphs and configuration. The output transactions
// are compared field by field, in order, while the receiver stalls at random.
// Configuration changes fall between phases, once the block has drained.
// ----------------------------------------------------------------------------
module testbench;
  import fsss_pkg::*;

  localparam int QUIET_FROM   = 1200;
  localparam int QUIET_TO     = 2200;
  localparam int DRAIN_CYCLES = 16;
  localparam int IDLE_PERCENT = 33;

  // Glyphs for nibbles F down to 0, nibble 0 in the low byte
  localparam logic [16*SEG_W-1:0] GLYPH_ROM = {
    8'h8E, 8'h9E, 8'h7A, 8'h9C, 8'h3E, 8'hEE, 8'hF6, 8'hFE,
    8'hE0, 8'hBE, 8'hB6, 8'h66, 8'hF2, 8'hDA, 8'h60, 8'hFC
  };

  // Phase plan: one bit per phase, phase 0 in bit 0
  localparam logic [4:0] HEX_PLAN = 5'b10011;
  localparam logic [4:0] CC_PLAN  = 5'b10101;

  typedef struct {
    logic [SEG_W-1:0]  segments;
    logic [DIGITS-1:0] enables;
    logic [POS_W-1:0]  position;
  } digit_drive_t;

  logic                      clk_i;
  logic                      rst_ni        = 1'b0;
  logic                      in_valid_i    = 1'b0;
  logic                      in_stall_o;
  logic signed [VALUE_W-1:0] shown_value_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i   = 1'b0;
  logic [SEG_W-1:0]          segment_lines_o;
  logic [DIGITS-1:0]         digit_enables_o;
  logic [POS_W-1:0]          digit_position_o;
  logic                      cfg_valid_i   = 1'b0;
  logic                      cfg_ready_o;
  logic [CFG_W-1:0]          cfg_index_i   = CFG_HEX_MODE;
  logic                      cfg_data_i    = 1'b0;

  // Display state as the block should hold it
  logic             hex_view       = 1'b0;
  logic             cathode_common = 1'b1;
  logic [POS_W-1:0] scan_slot      = '0;
  logic [SEG_W-1:0] kept_glyphs [DIGITS];

  logic signed [VALUE_W-1:0] pending_values [$];
  digit_drive_t              expected_drives [$];
  int                        mismatch_count = 0;
  int                        cycle_count    = 0;
  logic                      value_taken    = 1'b0;
  logic                      steady_window;

  assign steady_window = (cycle_count >= QUIET_FROM) && (cycle_count < QUIET_TO);

  four_digit_seven_segment_scanner_top u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .shown_value_i    (shown_value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .segment_lines_o  (segment_lines_o),
    .digit_enables_o  (digit_enables_o),
    .digit_position_o (digit_position_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [SEG_W-1:0] glyph_of(input logic [3:0] nibble);
    return GLYPH_ROM[nibble*SEG_W +: SEG_W];
  endfunction

  // Rebuild all four kept glyphs from the value seen on the digit 0 tick
  task automatic refill_glyphs(input logic signed [VALUE_W-1:0] value);
    int level;
    int mag;
    int slot;
    level = value;
    if (hex_view) begin
      for (slot = 0; slot < DIGITS; slot++)
        kept_glyphs[slot] = glyph_of(value[DATA_W-1-4*slot -: 4]);
    end else if (level > DEC_MAX) begin
      for (slot = 0; slot < DIGITS; slot++) kept_glyphs[slot] = SEG_TOP;
    end else if (level < DEC_MIN) begin
      for (slot = 0; slot < DIGITS; slot++) kept_glyphs[slot] = SEG_LOW;
    end else begin
      mag  = (level < 0) ? -level : level;
      slot = DIGITS - 1;
      // zero still shows one digit on the right
      if (mag == 0) begin
        kept_glyphs[slot] = glyph_of(4'd0);
        slot--;
      end
      while (mag != 0 && slot >= 0) begin
        kept_glyphs[slot] = glyph_of(4'(mag % 10));
        mag = mag / 10;
        slot--;
      end
      while (slot >= 0) begin
        kept_glyphs[slot] = SEG_BLANK;
        slot--;
      end
      if (level < 0) kept_glyphs[0] = SEG_MINUS;
    end
  endtask

  // Work out the digit drive for one refresh tick and advance the scan
  task automatic predict_digit_drive(input logic signed [VALUE_W-1:0] value);
    digit_drive_t drive;
    if (scan_slot == '0) refill_glyphs(value);
    drive.position = scan_slot;
    drive.segments = kept_glyphs[scan_slot];
    drive.enables  = DIGITS'(1) << scan_slot;
    if (cathode_common) begin
      drive.enables = ~drive.enables;
    end else begin
      drive.segments = ~drive.segments;
    end
    expected_drives.push_back(drive);
    scan_slot = scan_slot + 1'b1;
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    mismatch_count++;
  endtask

  // Mostly displayable decimals, with zero, the overflow edges and raw noise; only raw noise when hex_focus is set
  function automatic logic signed [VALUE_W-1:0] random_shown_value(input bit hex_focus);
    int pick;
    int level;
    pick = $urandom_range(0, 99);
    if (hex_focus || pick >= 65) begin
      level = int'($urandom_range(0, 131071)) - 65536;
    end else if (pick < 40) begin
      level = int'($urandom_range(0, 10998)) - 999;
    end else if (pick < 55) begin
      level = int'($urandom_range(0, 18)) - 9;
    end else if (pick < 60) begin
      level = int'($urandom_range(9990, 10010));
    end else begin
      level = -int'($urandom_range(990, 1010));
    end
    return level[VALUE_W-1:0];
  endfunction

  // Queue one full scan: the shown value on digit 0, filler on the rest
  task automatic queue_scan(input logic signed [VALUE_W-1:0] value);
    pending_values.push_back(value);
    repeat (DIGITS - 1) pending_values.push_back(random_shown_value(1'b1));
  endtask

  task automatic write_register(input logic [CFG_W-1:0] index, input logic bit_value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= bit_value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (index == CFG_HEX_MODE) begin
      hex_view = bit_value;
    end else begin
      cathode_common = bit_value;
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_until_drained();
    while (pending_values.size() != 0 || expected_drives.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Driver: record accepted transactions and predict their results
  always @(posedge clk_i) begin
    value_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      predict_digit_drive(shown_value_i);
      void'(pending_values.pop_front());
    end
  end

  // Driver: present the next value or idle; hold a stalled transaction
  always @(negedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni && (!in_valid_i || value_taken)) begin
      if (pending_values.size() != 0 &&
          (steady_window || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
        in_valid_i    <= 1'b1;
        shown_value_i <= pending_values[0];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_stall_i <= rst_ni && !steady_window && ($urandom_range(0, 99) < IDLE_PERCENT);
  end

  // Monitor: compare each output transaction with the oldest prediction
  always @(posedge clk_i) begin
    digit_drive_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_drives.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction: pos %0d seg %02h en %01h",
                                  digit_position_o, segment_lines_o, digit_enables_o));
      end else begin
        want = expected_drives.pop_front();
        if (digit_position_o !== want.position)
          report_mismatch($sformatf("digit_position got %0d expected %0d",
                                    digit_position_o, want.position));
        if (segment_lines_o !== want.segments)
          report_mismatch($sformatf("segment_lines pos %0d got %02h expected %02h",
                                    want.position, segment_lines_o, want.segments));
        if (digit_enables_o !== want.enables)
          report_mismatch($sformatf("digit_enables pos %0d got %01h expected %01h",
                                    want.position, digit_enables_o, want.enables));
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int count;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed decimal scans at reset settings: zero and the overflow edges
    queue_scan(17'sd0);
    queue_scan(17'sd9999);
    queue_scan(17'sd10000);
    queue_scan(-17'sd999);
    queue_scan(-17'sd1000);
    wait_until_drained();

    // Directed hex scan with the sign bit set
    write_register(CFG_HEX_MODE, 1'b1);
    queue_scan(17'h1_C3A5);
    wait_until_drained();

    // Random phases across every polarity and mode pairing
    for (int phase = 0; phase < 5; phase++) begin
      write_register(CFG_COMMON_CATHODE, CC_PLAN[phase]);
      write_register(CFG_HEX_MODE, HEX_PLAN[phase]);
      count = 290 + $urandom_range(0, 20);
      repeat (count) pending_values.push_back(random_shown_value(HEX_PLAN[phase]));
      wait_until_drained();
    end

    if (mismatch_count == 0 && expected_drives.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Bound the run
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
